// ===== rtl/sart_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sart_pkg
// Shared types and constants of the SART slowness reconstruction engine.
// ----------------------------------------------------------------------------
package sart_pkg;

  // default geometry
  localparam int GRID_CELLS_DEF    = 256;
  localparam int RAY_SLOTS_DEF     = 128;
  localparam int SEGMENT_SLOTS_DEF = 4096;

  // register reset values
  localparam logic [7:0]  RELAX_RST = 8'd51;
  localparam logic [19:0] FLOOR_RST = 20'd51200;
  localparam logic [19:0] CEIL_RST  = 20'd768000;
  localparam logic [19:0] START_RST = 20'd102400;

  // stream word widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OP_W        = 2;
  localparam int STS_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  // shared restoring divider
  localparam int         DVD_W     = 56;
  localparam int         DVS_W     = 40;
  localparam logic [5:0] DIV_STEPS = 6'd56;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_ITER  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_RAY_FULL = 2'd1,
    STS_SEG_FULL = 2'd2
  } sts_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELAX = 2'd0,
    CFG_FLOOR = 2'd1,
    CFG_CEIL  = 2'd2,
    CFG_START = 2'd3
  } cfg_e;

endpackage

// ===== rtl/sart_slowness_reconstruction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sart_slowness_reconstruction
// SART engine: ray segment store, per-ray residual back projection and
// relaxed, clamped slowness update.
// ----------------------------------------------------------------------------
// Every op gives one result word. After reset the map is filled with the
// reset start value before the first word is taken. An iterate op first
// clears the accumulators, then per complete ray runs the forward sum and
// the back projection (the weight w needs a 56-step restoring divide),
// then updates each cell, with a divide of the relaxed correction for
// cells that carry weight. The slowness map, the accumulators, the
// segment store and the ray store each sit in a one-port-read RAM, and all
// work is read-modify-write on them one entry at a time.
module sart_slowness_reconstruction #(
  parameter int GRID_CELLS    = sart_pkg::GRID_CELLS_DEF,
  parameter int RAY_SLOTS     = sart_pkg::RAY_SLOTS_DEF,
  parameter int SEGMENT_SLOTS = sart_pkg::SEGMENT_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // fields low to high: cell_index[8], seg_length[17], travel_time[20]
  input  logic [sart_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // fields: op[2]
  input  logic [sart_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // fields low to high: cell_slowness[20], ray_count[8], pass_count[16]
  output logic [sart_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // fields: status[2]
  output logic [sart_pkg::STS_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sart_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sart_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import sart_pkg::*;

  localparam int CW     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int RAW    = (RAY_SLOTS > 1) ? $clog2(RAY_SLOTS) : 1;
  localparam int RCW    = $clog2(RAY_SLOTS + 1);
  localparam int SAW    = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
  localparam int SCW    = $clog2(SEGMENT_SLOTS + 1);
  localparam int PRED_W = 37 + SCW;
  localparam int TOT_W  = 17 + SCW;
  localparam int SEG_W  = 25;
  localparam int RAY_W  = 20 + SCW;
  localparam int ACC_W  = 80;

  typedef enum logic [23:0] {
    S_INIT  = 24'h000001,
    S_IDLE  = 24'h000002,
    S_CLEAR = 24'h000004,
    S_READ  = 24'h000008,
    S_ACLR  = 24'h000010,
    S_RCHK  = 24'h000020,
    S_RWAIT = 24'h000040,
    S_ARD   = 24'h000080,
    S_ASEG  = 24'h000100,
    S_ASLOW = 24'h000200,
    S_AMAC  = 24'h000400,
    S_RES   = 24'h000800,
    S_BRD   = 24'h001000,
    S_BSEG  = 24'h002000,
    S_BDIV  = 24'h004000,
    S_BW2   = 24'h008000,
    S_BACC  = 24'h010000,
    S_NRAY  = 24'h020000,
    S_CRD   = 24'h040000,
    S_CCHK  = 24'h080000,
    S_CSGN  = 24'h100000,
    S_CDIV  = 24'h200000,
    S_CNXT  = 24'h400000,
    S_DONE  = 24'h800000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [7:0]  relax_q;
  logic [19:0] floor_q, ceil_q, start_q;

  // counters and pass control
  logic [CW-1:0]    sweep_q, sweep_d;
  logic [SCW-1:0]   seg_used_q, seg_used_d;
  logic [RCW-1:0]   ray_used_q, ray_used_d;
  logic [15:0]      pass_q, pass_d;
  logic [RCW-1:0]   ray_q, ray_d;
  logic [SCW-1:0]   first_q, first_d, last_q, last_d, k_q, k_d;
  logic [19:0]      time_q, time_d;
  logic [7:0]       cell_q, cell_d;
  logic [16:0]      len_q, len_d;
  logic [36:0]      prod_q, prod_d;
  logic [PRED_W-1:0] pred_q, pred_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic signed [31:0] res_q, res_d;
  logic [16:0]      w_q, w_d, w2_q, w2_d;
  logic [31:0]      wt_q, wt_d;
  logic [19:0]      slow_q, slow_d;
  logic signed [56:0] num_q, num_d;
  logic             neg_q, neg_d;
  logic             rd_oob_q, rd_oob_d;

  // divider
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d, rem_q, rem_d;
  logic [5:0]       dcnt_q, dcnt_d;
  logic [DVS_W:0]   rem_sh;
  logic             div_ge;
  logic [DVS_W-1:0] rem_nx;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_sts_q, out_sts_d;
  logic [19:0] out_slow_q, out_slow_d;
  logic [7:0]  out_rays_q, out_rays_d;
  logic [15:0] out_pass_q, out_pass_d;
  logic        load_out;
  sts_e        load_sts;
  logic [19:0] load_slow;

  // RAM ports
  logic             slow_we, acc_we, seg_we, ray_we;
  logic [CW-1:0]    slow_waddr, slow_raddr, acc_waddr, acc_raddr;
  logic [19:0]      slow_wdata, slow_rdata;
  logic [ACC_W-1:0] acc_wdata, acc_rdata;
  logic [SEG_W-1:0] seg_wdata, seg_rdata;
  logic [RAY_W-1:0] ray_wdata, ray_rdata;

  // input word fields
  logic [7:0]  in_cell;
  logic [16:0] in_len;
  logic [19:0] in_time;
  op_e         in_op;
  logic        in_fire, out_fire;
  logic [7:0]  seg_cell;
  logic        in_cell_ok, seg_cell_ok;

  // arithmetic
  logic signed [PRED_W:0]  diff, diff_sh;
  logic signed [49:0]      acc_prod;
  logic signed [50:0]      acc_sum;
  logic [32:0]             wt_sum;
  logic [33:0]             w_sq;
  logic [55:0]             num_mag;
  logic signed [49:0]      s_new, s_floor, q_s;

  assign in_cell = s_axis_tdata[7:0];
  assign in_len  = s_axis_tdata[24:8];
  assign in_time = s_axis_tdata[44:25];
  assign in_op   = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = out_valid_q && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_sts_q;
  assign m_axis_tdata  = {4'b0, out_pass_q, out_rays_q, out_slow_q};

  assign seg_cell    = seg_rdata[24:17];
  assign in_cell_ok  = int'(in_cell) < GRID_CELLS;
  assign seg_cell_ok = int'(seg_cell) < GRID_CELLS;

  // one restoring divide step
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = div_ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];

  // residual, floored to 1/16 of the travel-time unit
  assign diff    = $signed({{(PRED_W-39){1'b0}}, time_q, 20'b0})
                 - $signed({1'b0, pred_q});
  assign diff_sh = diff >>> 16;

  // correction and weight accumulation
  assign acc_prod = res_q * $signed({1'b0, w2_q});
  assign acc_sum  = $signed({{3{acc_rdata[79]}}, acc_rdata[79:32]})
                  + $signed({acc_prod[49], acc_prod});
  assign wt_sum   = {1'b0, acc_rdata[31:0]} + 33'(w2_q);
  assign w_sq     = 34'(w_q) * 34'(w_q);

  // cell update; the magnitude is taken from the current product sign
  assign num_mag = num_q[56] ? 56'(-num_q) : 56'(num_q);
  assign q_s     = neg_q ? -$signed({2'b0, dvd_q[47:0]}) : $signed({2'b0, dvd_q[47:0]});
  assign s_new   = $signed({30'b0, slow_q}) + q_s;
  assign s_floor = (s_new < $signed({30'b0, floor_q})) ? $signed({30'b0, floor_q}) : s_new;

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    seg_used_d = seg_used_q;
    ray_used_d = ray_used_q;
    pass_d     = pass_q;
    ray_d      = ray_q;
    first_d    = first_q;
    last_d     = last_q;
    k_d        = k_q;
    time_d     = time_q;
    cell_d     = cell_q;
    len_d      = len_q;
    prod_d     = prod_q;
    pred_d     = pred_q;
    total_d    = total_q;
    res_d      = res_q;
    w_d        = w_q;
    w2_d       = w2_q;
    wt_d       = wt_q;
    slow_d     = slow_q;
    num_d      = num_q;
    neg_d      = neg_q;
    rd_oob_d   = rd_oob_q;
    dvd_d      = dvd_q;
    dvs_d      = dvs_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    out_valid_d = out_valid_q;
    out_sts_d  = out_sts_q;
    out_slow_d = out_slow_q;
    out_rays_d = out_rays_q;
    out_pass_d = out_pass_q;
    load_out   = 1'b0;
    load_sts   = STS_OK;
    load_slow  = '0;

    slow_we    = 1'b0;
    slow_waddr = sweep_q;
    slow_wdata = start_q;
    slow_raddr = sweep_q;
    acc_we     = 1'b0;
    acc_waddr  = sweep_q;
    acc_wdata  = '0;
    acc_raddr  = sweep_q;
    seg_we     = 1'b0;
    seg_wdata  = {in_cell, in_len};
    ray_we     = 1'b0;
    ray_wdata  = {in_time, SCW'(seg_used_q + 1'b1)};

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        slow_we    = 1'b1;
        slow_wdata = START_RST;
        if (sweep_q == CW'(GRID_CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_IDLE: begin
        slow_raddr = CW'(in_cell);
        if (in_fire) begin
          unique case (in_op)
            OP_CLEAR: begin
              seg_used_d = '0;
              ray_used_d = '0;
              pass_d     = '0;
              sweep_d    = '0;
              state_d    = S_CLEAR;
            end
            OP_ADD: begin
              load_out = 1'b1;
              if (int'(ray_used_q) >= RAY_SLOTS) begin
                load_sts = STS_RAY_FULL;
              end else if (int'(seg_used_q) >= SEGMENT_SLOTS) begin
                load_sts = STS_SEG_FULL;
              end else begin
                seg_we     = 1'b1;
                seg_used_d = seg_used_q + 1'b1;
                if (s_axis_tlast) begin
                  ray_we     = 1'b1;
                  ray_used_d = ray_used_q + 1'b1;
                end
              end
            end
            OP_ITER: begin
              sweep_d = '0;
              state_d = S_ACLR;
            end
            OP_READ: begin
              rd_oob_d = !in_cell_ok;
              state_d  = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        slow_we = 1'b1;
        if (sweep_q == CW'(GRID_CELLS - 1)) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_READ: begin
        load_out  = 1'b1;
        load_slow = rd_oob_q ? 20'd0 : slow_rdata;
        state_d   = S_IDLE;
      end
      S_ACLR: begin
        acc_we = 1'b1;
        if (sweep_q == CW'(GRID_CELLS - 1)) begin
          ray_d   = '0;
          first_d = '0;
          state_d = S_RCHK;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_RCHK: begin
        if (ray_q == ray_used_q) begin
          sweep_d = '0;
          state_d = S_CRD;
        end else begin
          state_d = S_RWAIT;
        end
      end
      S_RWAIT: begin
        time_d  = ray_rdata[RAY_W-1:SCW];
        last_d  = ray_rdata[SCW-1:0];
        pred_d  = '0;
        total_d = '0;
        k_d     = first_q;
        state_d = S_ARD;
      end
      S_ARD: begin
        state_d = (k_q == last_q) ? S_RES : S_ASEG;
      end
      S_ASEG: begin
        cell_d     = seg_cell;
        len_d      = seg_rdata[16:0];
        slow_raddr = CW'(seg_cell);
        if (seg_cell_ok) begin
          state_d = S_ASLOW;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_ARD;
        end
      end
      S_ASLOW: begin
        prod_d  = 37'(slow_rdata) * 37'(len_q);
        state_d = S_AMAC;
      end
      S_AMAC: begin
        pred_d  = pred_q + PRED_W'(prod_q);
        total_d = total_q + TOT_W'(len_q);
        k_d     = k_q + 1'b1;
        state_d = S_ARD;
      end
      S_RES: begin
        if (total_q == '0) begin
          state_d = S_NRAY;
        end else begin
          if ((&diff_sh[PRED_W:31]) || !(|diff_sh[PRED_W:31])) begin
            res_d = diff_sh[31:0];
          end else begin
            res_d = diff_sh[PRED_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end
          k_d     = first_q;
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        state_d = (k_q == last_q) ? S_NRAY : S_BSEG;
      end
      S_BSEG: begin
        cell_d = seg_cell;
        len_d  = seg_rdata[16:0];
        if (seg_cell_ok) begin
          dvd_d   = DVD_W'({seg_rdata[16:0], 16'b0});
          dvs_d   = DVS_W'(total_q);
          rem_d   = '0;
          dcnt_d  = DIV_STEPS;
          state_d = S_BDIV;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_BRD;
        end
      end
      S_BDIV: begin
        if (dcnt_q != '0) begin
          dvd_d  = {dvd_q[DVD_W-2:0], div_ge};
          rem_d  = rem_nx;
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          w_d     = dvd_q[16:0];
          state_d = S_BW2;
        end
      end
      S_BW2: begin
        w2_d      = w_sq[32:16];
        acc_raddr = CW'(cell_q);
        state_d   = S_BACC;
      end
      S_BACC: begin
        acc_we    = 1'b1;
        acc_waddr = CW'(cell_q);
        if ((&acc_sum[50:47]) || !(|acc_sum[50:47])) begin
          acc_wdata[79:32] = acc_sum[47:0];
        end else begin
          acc_wdata[79:32] = acc_sum[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        acc_wdata[31:0] = wt_sum[32] ? 32'hFFFF_FFFF : wt_sum[31:0];
        k_d     = k_q + 1'b1;
        state_d = S_BRD;
      end
      S_NRAY: begin
        first_d = last_q;
        ray_d   = ray_q + 1'b1;
        state_d = S_RCHK;
      end
      S_CRD: begin
        state_d = S_CCHK;
      end
      S_CCHK: begin
        wt_d    = acc_rdata[31:0];
        slow_d  = slow_rdata;
        num_d   = $signed(acc_rdata[79:32]) * $signed({1'b0, relax_q});
        state_d = (acc_rdata[31:0] == '0) ? S_CNXT : S_CSGN;
      end
      S_CSGN: begin
        neg_d   = num_q[56];
        dvd_d   = num_mag;
        dvs_d   = {wt_q, 8'b0};
        rem_d   = '0;
        dcnt_d  = DIV_STEPS;
        state_d = S_CDIV;
      end
      S_CDIV: begin
        if (dcnt_q != '0) begin
          dvd_d  = {dvd_q[DVD_W-2:0], div_ge};
          rem_d  = rem_nx;
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          slow_we    = 1'b1;
          slow_wdata = (s_floor > $signed({30'b0, ceil_q})) ? ceil_q : s_floor[19:0];
          state_d    = S_CNXT;
        end
      end
      S_CNXT: begin
        if (sweep_q == CW'(GRID_CELLS - 1)) begin
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_DONE: begin
        if (pass_q != 16'hFFFF) begin
          pass_d = pass_q + 1'b1;
        end
        load_out = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
      out_sts_d   = load_sts;
      out_slow_d  = load_slow;
      out_rays_d  = (int'(ray_used_d) > 255) ? 8'hFF : 8'(ray_used_d);
      out_pass_d  = pass_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= RELAX_RST;
      floor_q <= FLOOR_RST;
      ceil_q  <= CEIL_RST;
      start_q <= START_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_RELAX: relax_q <= cfg_data_i[7:0];
        CFG_FLOOR: floor_q <= cfg_data_i;
        CFG_CEIL:  ceil_q  <= cfg_data_i;
        CFG_START: start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      seg_used_q  <= '0;
      ray_used_q  <= '0;
      pass_q      <= '0;
      ray_q       <= '0;
      first_q     <= '0;
      last_q      <= '0;
      k_q         <= '0;
      dcnt_q      <= '0;
      rd_oob_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      seg_used_q  <= seg_used_d;
      ray_used_q  <= ray_used_d;
      pass_q      <= pass_d;
      ray_q       <= ray_d;
      first_q     <= first_d;
      last_q      <= last_d;
      k_q         <= k_d;
      dcnt_q      <= dcnt_d;
      rd_oob_q    <= rd_oob_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    time_q     <= time_d;
    cell_q     <= cell_d;
    len_q      <= len_d;
    prod_q     <= prod_d;
    pred_q     <= pred_d;
    total_q    <= total_d;
    res_q      <= res_d;
    w_q        <= w_d;
    w2_q       <= w2_d;
    wt_q       <= wt_d;
    slow_q     <= slow_d;
    num_q      <= num_d;
    neg_q      <= neg_d;
    dvd_q      <= dvd_d;
    dvs_q      <= dvs_d;
    rem_q      <= rem_d;
    out_sts_q  <= out_sts_d;
    out_slow_q <= out_slow_d;
    out_rays_q <= out_rays_d;
    out_pass_q <= out_pass_d;
  end

  sart_ram #(.WIDTH(20), .DEPTH(GRID_CELLS)) u_slow_ram (
    .clk_i   (clk_i),
    .we_i    (slow_we),
    .waddr_i (slow_waddr),
    .wdata_i (slow_wdata),
    .raddr_i (slow_raddr),
    .rdata_o (slow_rdata)
  );

  // {correction[48], weight[32]}
  sart_ram #(.WIDTH(ACC_W), .DEPTH(GRID_CELLS)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // {cell[8], length[17]}
  sart_ram #(.WIDTH(SEG_W), .DEPTH(SEGMENT_SLOTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_used_q[SAW-1:0]),
    .wdata_i (seg_wdata),
    .raddr_i (k_q[SAW-1:0]),
    .rdata_o (seg_rdata)
  );

  // {travel time[20], end pointer}
  sart_ram #(.WIDTH(RAY_W), .DEPTH(RAY_SLOTS)) u_ray_ram (
    .clk_i   (clk_i),
    .we_i    (ray_we),
    .waddr_i (ray_used_q[RAW-1:0]),
    .wdata_i (ray_wdata),
    .raddr_i (ray_q[RAW-1:0]),
    .rdata_o (ray_rdata)
  );

endmodule

// ===== rtl/sart_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sart_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
